### rtl/core/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

    // Pipeline stage positions
    localparam int NUM_STAGES = 8;
    localparam int ST_CLAMP   = 0;
    localparam int ST_PROD    = 1;
    localparam int ST_TERM    = 2;
    localparam int ST_SUM     = 3;
    localparam int ST_NUM     = 4;
    localparam int ST_RECIP   = 5;
    localparam int ST_FIX     = 6;
    localparam int ST_OUT     = 7;

    typedef logic [NUM_STAGES-1:0] stage_en_t;

    // Hue sector codes
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    // Terms are in units of 1/6000 percent, at most 600000
    localparam int TERM_W  = 20;
    // term * 255 plus the rounding bias
    localparam int NUM_W   = 28;
    localparam int QUO_W   = 9;
    localparam int CHAN_W  = 8;

    localparam logic [TERM_W-1:0] TERM_DEN  = 20'd600000;
    localparam logic [NUM_W-1:0]  TERM_BIAS = 28'd299999;
    localparam logic [NUM_W-1:0]  CHAN_GAIN = 28'd255;

    // Reciprocal of the divisor, scaled by 2^RECIP_SHIFT and rounded down
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd600000);

endpackage

`default_nettype wire

### rtl/core/hsv2rgb_sector.sv
// Input clamp and hue sector / offset split stage.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_sector
    import hsv2rgb_pkg::*;
(
    input  wire logic      aclk,
    input  wire stage_en_t en,
    input  wire logic [8:0] hue,
    input  wire logic [6:0] saturation,
    input  wire logic [6:0] brightness,
    output sector_t         sector_reg,
    output logic [5:0]      offset_reg,
    output logic [6:0]      sat_reg,
    output logic [6:0]      bri_reg
);

    logic [8:0] hue_clamp;
    logic [8:0] offset_full;
    sector_t    sector_next;
    logic [5:0] offset_next;
    logic [6:0] sat_next;
    logic [6:0] bri_next;

    // Clamp the inputs and split hue into sector and offset within it
    always_comb begin
        hue_clamp = (hue > 9'd360) ? 9'd360 : hue;
        sat_next  = (saturation > 7'd100) ? 7'd100 : saturation;
        bri_next  = (brightness > 7'd100) ? 7'd100 : brightness;
        if (hue_clamp < 9'd60) begin
            sector_next = SEC_R_TO_Y;
            offset_full = hue_clamp;
        end else if (hue_clamp < 9'd120) begin
            sector_next = SEC_Y_TO_G;
            offset_full = hue_clamp - 9'd60;
        end else if (hue_clamp < 9'd180) begin
            sector_next = SEC_G_TO_C;
            offset_full = hue_clamp - 9'd120;
        end else if (hue_clamp < 9'd240) begin
            sector_next = SEC_C_TO_B;
            offset_full = hue_clamp - 9'd180;
        end else if (hue_clamp < 9'd300) begin
            sector_next = SEC_B_TO_M;
            offset_full = hue_clamp - 9'd240;
        end else if (hue_clamp < 9'd360) begin
            sector_next = SEC_M_TO_R;
            offset_full = hue_clamp - 9'd300;
        end else begin
            // full turn wraps back to the start of the red sector
            sector_next = SEC_R_TO_Y;
            offset_full = 9'd0;
        end
        offset_next = offset_full[5:0];
    end

    // Hold the stage while downstream stalls
    always_ff @(posedge aclk) begin
        if (en[ST_CLAMP]) begin
            sector_reg <= sector_next;
            offset_reg <= offset_next;
            sat_reg    <= sat_next;
            bri_reg    <= bri_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/hsv2rgb_terms.sv
// Three-stage pipeline that forms the v, vmin, vinc and vdec terms.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_terms
    import hsv2rgb_pkg::*;
(
    input  wire logic              aclk,
    input  wire stage_en_t         en,
    input  wire logic [5:0]        offset,
    input  wire logic [6:0]        sat,
    input  wire logic [6:0]        bri,
    output logic [TERM_W-1:0]      tv_reg,
    output logic [TERM_W-1:0]      tmin_reg,
    output logic [TERM_W-1:0]      tinc_reg,
    output logic [TERM_W-1:0]      tdec_reg
);

    logic [13:0]       vs_reg, vs_next;
    logic [13:0]       vcs_reg, vcs_next;
    logic [5:0]        offset1_reg;
    logic [6:0]        bri1_reg;
    logic [6:0]        sat_comp;

    logic [TERM_W-1:0] ta2_reg, ta2_next;
    logic [TERM_W-1:0] tmin2_reg, tmin2_next;
    logic [TERM_W-1:0] tv2_reg, tv2_next;

    logic [TERM_W-1:0] tinc_next, tdec_next;

    // First products: v*s and v*(100-s)
    always_comb begin
        sat_comp = 7'd100 - sat;
        vs_next  = {7'd0, bri} * {7'd0, sat};
        vcs_next = {7'd0, bri} * {7'd0, sat_comp};
    end

    // Second products: scale each into 1/6000 percent units
    always_comb begin
        ta2_next   = {6'd0, vs_reg} * {14'd0, offset1_reg};
        tmin2_next = {6'd0, vcs_reg} * 20'd60;
        tv2_next   = {13'd0, bri1_reg} * 20'd6000;
    end

    // Rising and falling ramps
    always_comb begin
        tinc_next = tmin2_reg + ta2_reg;
        tdec_next = tv2_reg - ta2_reg;
    end

    // Advance each stage when its slot may move
    always_ff @(posedge aclk) begin
        if (en[ST_PROD]) begin
            vs_reg      <= vs_next;
            vcs_reg     <= vcs_next;
            offset1_reg <= offset;
            bri1_reg    <= bri;
        end
        if (en[ST_TERM]) begin
            ta2_reg   <= ta2_next;
            tmin2_reg <= tmin2_next;
            tv2_reg   <= tv2_next;
        end
        if (en[ST_SUM]) begin
            tv_reg   <= tv2_reg;
            tmin_reg <= tmin2_reg;
            tinc_reg <= tinc_next;
            tdec_reg <= tdec_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/hsv2rgb_scale.sv
// Three-stage scaler: term * 255 / 600000, rounded to nearest, ties down.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_scale
    import hsv2rgb_pkg::*;
(
    input  wire logic              aclk,
    input  wire stage_en_t         en,
    input  wire logic [TERM_W-1:0] term,
    output logic [CHAN_W-1:0]      chan_reg
);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [NUM_W-1:0]  num5_reg;
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [NUM_W-1:0]  back;
    logic [NUM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo_fix;
    logic [CHAN_W-1:0] chan_next;

    // Numerator with the rounding bias
    always_comb begin
        num_next = {{(NUM_W-TERM_W){1'b0}}, term} * CHAN_GAIN + TERM_BIAS;
    end

    // Estimate the quotient by the reciprocal; it is exact or one low
    always_comb begin
        prod     = {{RECIP_W{1'b0}}, num_reg} * {{NUM_W{1'b0}}, RECIP_MUL};
        quo_next = prod[RECIP_SHIFT +: QUO_W];
    end

    // Correct the estimate once and saturate to eight bits
    always_comb begin
        back    = {{(NUM_W-QUO_W){1'b0}}, quo_reg} *
                  {{(NUM_W-TERM_W){1'b0}}, TERM_DEN};
        rem     = num5_reg - back;
        quo_fix = quo_reg + {{(QUO_W-1){1'b0}},
                             (rem >= {{(NUM_W-TERM_W){1'b0}}, TERM_DEN})};
        chan_next = (quo_fix > 9'd255) ? 8'd255 : quo_fix[CHAN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[ST_NUM]) begin
            num_reg <= num_next;
        end
        if (en[ST_RECIP]) begin
            quo_reg  <= quo_next;
            num5_reg <= num_reg;
        end
        if (en[ST_FIX]) begin
            chan_reg <= chan_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel converter with stream handshakes.
`timescale 1ns / 1ps
`default_nettype none

// Converts one pixel given as hue in degrees (0..360) and saturation and value
// in percent (0..100) into 8-bit red, green and blue; inputs above range clamp
// to the top of their range, and each channel is scaled from percent by 255/100
// and rounded to nearest with exact halves going down. The block is an
// eight-stage pipeline: it takes one pixel every clock cycle unless the output
// stalls, and each result passes through the stage registers in order before
// it is valid on the output. The stages are the input clamp and sector split,
// the two multiplies and the sums that form the colour terms, the gain,
// reciprocal multiply and correction that scale them, and the channel routing
// into the output register. Each stage holds its own valid bit, so empty slots
// fill while the output waits, and s_ready stays high whenever the last stage
// is empty or being taken. It keeps no state between pixels.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [8:0]  s_hue,
    input  wire logic [6:0]  s_saturation,
    input  wire logic [6:0]  s_brightness,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue
);

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    stage_en_t             en;

    sector_t               sector0;
    logic [5:0]            offset0;
    logic [6:0]            sat0;
    logic [6:0]            bri0;
    sector_t               sec_reg [ST_PROD:ST_FIX];

    logic [TERM_W-1:0]     tv, tmin, tinc, tdec;
    logic [CHAN_W-1:0]     cv, cmin, cinc, cdec;

    logic [7:0]            red_reg, red_next;
    logic [7:0]            green_reg, green_next;
    logic [7:0]            blue_reg, blue_next;

    // A stage may load when it is empty or its content moves on
    always_comb begin
        en[ST_OUT] = !vld_reg[ST_OUT] || m_ready;
        for (int i = ST_OUT - 1; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        s_ready = en[ST_CLAMP];
    end

    // Carry valid bits along with the data
    always_comb begin
        vld_next = vld_reg;
        if (en[ST_CLAMP]) begin
            vld_next[ST_CLAMP] = s_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (en[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    hsv2rgb_sector u_sector (
        .aclk       (aclk),
        .en         (en),
        .hue        (s_hue),
        .saturation (s_saturation),
        .brightness (s_brightness),
        .sector_reg (sector0),
        .offset_reg (offset0),
        .sat_reg    (sat0),
        .bri_reg    (bri0)
    );

    hsv2rgb_terms u_terms (
        .aclk     (aclk),
        .en       (en),
        .offset   (offset0),
        .sat      (sat0),
        .bri      (bri0),
        .tv_reg   (tv),
        .tmin_reg (tmin),
        .tinc_reg (tinc),
        .tdec_reg (tdec)
    );

    hsv2rgb_scale u_scale_v (
        .aclk     (aclk),
        .en       (en),
        .term     (tv),
        .chan_reg (cv)
    );

    hsv2rgb_scale u_scale_min (
        .aclk     (aclk),
        .en       (en),
        .term     (tmin),
        .chan_reg (cmin)
    );

    hsv2rgb_scale u_scale_inc (
        .aclk     (aclk),
        .en       (en),
        .term     (tinc),
        .chan_reg (cinc)
    );

    hsv2rgb_scale u_scale_dec (
        .aclk     (aclk),
        .en       (en),
        .term     (tdec),
        .chan_reg (cdec)
    );

    // Delay the sector alongside the arithmetic
    always_ff @(posedge aclk) begin
        if (en[ST_PROD]) begin
            sec_reg[ST_PROD] <= sector0;
        end
        for (int i = ST_PROD + 1; i <= ST_FIX; i++) begin
            if (en[i]) begin
                sec_reg[i] <= sec_reg[i-1];
            end
        end
    end

    // Route the scaled terms to the channels by sector
    always_comb begin
        case (sec_reg[ST_FIX])
            SEC_R_TO_Y: begin
                red_next = cv;   green_next = cinc; blue_next = cmin;
            end
            SEC_Y_TO_G: begin
                red_next = cdec; green_next = cv;   blue_next = cmin;
            end
            SEC_G_TO_C: begin
                red_next = cmin; green_next = cv;   blue_next = cinc;
            end
            SEC_C_TO_B: begin
                red_next = cmin; green_next = cdec; blue_next = cv;
            end
            SEC_B_TO_M: begin
                red_next = cinc; green_next = cmin; blue_next = cv;
            end
            default: begin
                red_next = cv;   green_next = cmin; blue_next = cdec;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_valid = vld_reg[ST_OUT];
    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

    // An empty last stage must leave the whole pipeline open to requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[ST_OUT] |-> s_ready)
        else $error("pipeline closed while output stage empty");

    // A full penultimate stage reaches the output when the sink is ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[ST_FIX] && m_ready) |=> m_valid)
        else $error("request lost between last two stages");

    // A request in flight is never dropped while the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($countones(vld_reg) >= $past($countones(vld_reg))))
        else $error("request dropped during stall");

endmodule

`default_nettype wire
